// ===== hw/rtl/gripper_close_goal_sequencer_unit_macros.svh =====
// Assertion macros shared by the gripper close goal sequencer RTL.
`ifndef GRIPPER_CLOSE_GOAL_SEQUENCER_UNIT_MACROS_SVH
`define GRIPPER_CLOSE_GOAL_SEQUENCER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GCGS_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`define GCGS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define GCGS_ASSERT_NOW(label, clk, rst_n, cond, expr, msg)
`define GCGS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

// ===== hw/rtl/gcgs_pkg.sv =====
// Types, constants and helper functions of the gripper close goal sequencer.
package gcgs_pkg;

    localparam int NUM_GOALS       = 9;
    localparam int ANGLE_W         = 16;
    localparam int TOL_W           = 15;
    localparam int WIDE_W          = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    localparam logic signed [ANGLE_W-1:0] CLOSE_ANGLE     = 16'sd3932;
    localparam logic signed [ANGLE_W-1:0] NEG_CLOSE_ANGLE = -16'sd3932;

    localparam logic signed [ANGLE_W-1:0] JOINT_ONE_RST   = 16'sd5004;
    localparam logic signed [ANGLE_W-1:0] JOINT_TWO_RST   = 16'sd6434;
    localparam logic signed [ANGLE_W-1:0] JOINT_THREE_RST = 16'sd0;
    localparam int                        TOL_RST_INT     = 41;
    localparam int                        MARGIN_RST_INT  = 41;
    localparam logic [TOL_W-1:0]          TOL_RST         = TOL_W'(TOL_RST_INT);
    localparam logic [TOL_W-1:0]          MARGIN_RST      = TOL_W'(MARGIN_RST_INT);
    localparam logic [WIDE_W-1:0]         WIDE_MARGIN_RST = WIDE_W'((6 * MARGIN_RST_INT + 2) / 5);

    // floor(x / 5) = (x * RECIP_5) >> RECIP_SHIFT, exact for x below 2**RECIP_SHIFT
    localparam int                RECIP_SHIFT = 22;
    localparam logic [19:0]       RECIP_5     = 20'd838861;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic [NUM_GOALS-1:0][ANGLE_W-1:0] t_goal_vec;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PINCHER_MODE = 3'd0,
        CFG_JOINT_ONE    = 3'd1,
        CFG_JOINT_TWO    = 3'd2,
        CFG_JOINT_THREE  = 3'd3,
        CFG_MATCH_TOL    = 3'd4,
        CFG_STOP_MARGIN  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                pincher_mode;
        logic signed [15:0]  joint_one_limit;
        logic signed [15:0]  joint_two_limit;
        logic signed [15:0]  joint_three_limit;
        logic [TOL_W-1:0]    match_tolerance;
        logic [TOL_W-1:0]    stop_margin;
        logic [WIDE_W-1:0]   wide_margin;
    } t_cfg;

    function automatic logic angle_near(input t_angle a, input t_angle b,
                                        input logic [TOL_W-1:0] tol);
        logic signed [17:0] d;
        logic [17:0]        mag;
        d   = {{2{a[15]}}, a} - {{2{b[15]}}, b};
        mag = d[17] ? 18'(-d) : 18'(d);
        return mag < {3'b000, tol};
    endfunction

    function automatic t_angle add_cap(input t_angle lim, input t_angle ang,
                                       input logic [WIDE_W-1:0] add);
        logic signed [17:0] s;
        logic signed [17:0] l;
        s = {{2{ang[15]}}, ang} + {2'b00, add};
        l = {{2{lim[15]}}, lim};
        return (s < l) ? t_angle'(s[15:0]) : lim;
    endfunction

    function automatic t_angle sub_floor(input t_angle lo, input t_angle ang,
                                         input logic [TOL_W-1:0] sub);
        logic signed [17:0] s;
        logic signed [17:0] l;
        s = {{2{ang[15]}}, ang} - {3'b000, sub};
        l = {{2{lo[15]}}, lo};
        return (s > l) ? t_angle'(s[15:0]) : lo;
    endfunction

endpackage

// ===== hw/rtl/gcgs_cmd_if.sv =====
// Command channel: close request, contact bits and measured joint angles.
interface gcgs_cmd_if;
    logic               valid;
    logic               ready;
    logic               close_req;
    logic [9:0]         contact_flags;
    logic signed [15:0] angle_0;
    logic signed [15:0] angle_1;
    logic signed [15:0] angle_2;
    logic signed [15:0] angle_3;
    logic signed [15:0] angle_4;
    logic signed [15:0] angle_5;
    logic signed [15:0] angle_6;
    logic signed [15:0] angle_7;
    logic signed [15:0] angle_8;

    modport source (
        output valid, close_req, contact_flags,
        output angle_0, angle_1, angle_2, angle_3, angle_4, angle_5, angle_6, angle_7, angle_8,
        input  ready
    );
    modport sink (
        input  valid, close_req, contact_flags,
        input  angle_0, angle_1, angle_2, angle_3, angle_4, angle_5, angle_6, angle_7, angle_8,
        output ready
    );
endinterface

// ===== hw/rtl/gcgs_goal_if.sv =====
// Result channel: nine joint goal angles.
interface gcgs_goal_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] goal_0;
    logic signed [15:0] goal_1;
    logic signed [15:0] goal_2;
    logic signed [15:0] goal_3;
    logic signed [15:0] goal_4;
    logic signed [15:0] goal_5;
    logic signed [15:0] goal_6;
    logic signed [15:0] goal_7;
    logic signed [15:0] goal_8;

    modport source (
        output valid,
        output goal_0, goal_1, goal_2, goal_3, goal_4, goal_5, goal_6, goal_7, goal_8,
        input  ready
    );
    modport sink (
        input  valid,
        input  goal_0, goal_1, goal_2, goal_3, goal_4, goal_5, goal_6, goal_7, goal_8,
        output ready
    );
endinterface

// ===== hw/rtl/gcgs_cfg.sv =====
// Configuration registers, including the derived wide-mode proximal margin.
module gcgs_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gcgs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcgs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output gcgs_pkg::t_cfg                    o_cfg
);
    gcgs_pkg::t_cfg   r_cfg;
    gcgs_pkg::t_cfg   n_cfg;
    logic [17:0]      wide_num;
    logic [37:0]      wide_prod;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (gcgs_pkg::t_cfg_idx'(i_cfg_idx))
                gcgs_pkg::CFG_PINCHER_MODE: n_cfg.pincher_mode      = i_cfg_wdata[0];
                gcgs_pkg::CFG_JOINT_ONE:    n_cfg.joint_one_limit   = i_cfg_wdata;
                gcgs_pkg::CFG_JOINT_TWO:    n_cfg.joint_two_limit   = i_cfg_wdata;
                gcgs_pkg::CFG_JOINT_THREE:  n_cfg.joint_three_limit = i_cfg_wdata;
                gcgs_pkg::CFG_MATCH_TOL:    n_cfg.match_tolerance   = i_cfg_wdata[14:0];
                gcgs_pkg::CFG_STOP_MARGIN:  n_cfg.stop_margin       = i_cfg_wdata[14:0];
                default: ;
            endcase
        end
        // round(1.2 * margin) = floor((6 * margin + 2) / 5)
        wide_num          = {n_cfg.stop_margin, 1'b0} + {1'b0, n_cfg.stop_margin, 2'b00}
                            + 18'd2;
        wide_prod         = 38'(wide_num) * 38'(gcgs_pkg::RECIP_5);
        n_cfg.wide_margin = wide_prod[gcgs_pkg::RECIP_SHIFT +: gcgs_pkg::WIDE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pincher_mode      <= 1'b0;
            r_cfg.joint_one_limit   <= gcgs_pkg::JOINT_ONE_RST;
            r_cfg.joint_two_limit   <= gcgs_pkg::JOINT_TWO_RST;
            r_cfg.joint_three_limit <= gcgs_pkg::JOINT_THREE_RST;
            r_cfg.match_tolerance   <= gcgs_pkg::TOL_RST;
            r_cfg.stop_margin       <= gcgs_pkg::MARGIN_RST;
            r_cfg.wide_margin       <= gcgs_pkg::WIDE_MARGIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== hw/rtl/gcgs_core.sv =====
// Next-goal logic for one tick: wide three-phase closing and pincher jaws.
module gcgs_core (
    input  gcgs_pkg::t_cfg       i_cfg,
    input  logic                 i_close,
    input  logic [8:0]           i_contact,
    input  gcgs_pkg::t_goal_vec  i_angle,
    input  gcgs_pkg::t_goal_vec  i_goal,
    output gcgs_pkg::t_goal_vec  o_goal
);
    gcgs_pkg::t_goal_vec n_goal;
    logic [2:0]          touch;
    logic                jaws_closed;
    logic                l1;
    logic                l2;
    logic                l3;
    int                  b;

    always_comb begin
        n_goal      = i_goal;
        touch       = {|i_contact[8:6], |i_contact[5:3], |i_contact[2:0]};
        jaws_closed = touch[0] && (touch[1] || touch[2]);
        l1          = 1'b0;
        l2          = 1'b0;
        l3          = 1'b0;
        b           = 0;
        if (i_close && !i_cfg.pincher_mode) begin
            for (int f = 0; f < 3; f++) begin
                b  = 3 * f;
                l1 = i_contact[b];
                l2 = i_contact[b+1];
                l3 = i_contact[b+2];
                if (!l1 && !l2 && !l3) begin
                    if (gcgs_pkg::angle_near(i_goal[b], '0, i_cfg.match_tolerance)) begin
                        n_goal[b]   = gcgs_pkg::CLOSE_ANGLE;
                        n_goal[b+1] = '0;
                        n_goal[b+2] = gcgs_pkg::NEG_CLOSE_ANGLE;
                    end else if (gcgs_pkg::angle_near(i_angle[b], gcgs_pkg::CLOSE_ANGLE,
                                                      i_cfg.match_tolerance)) begin
                        n_goal[b] = i_cfg.joint_one_limit;
                    end else if (gcgs_pkg::angle_near(i_angle[b], i_cfg.joint_one_limit,
                                                      i_cfg.match_tolerance)) begin
                        n_goal[b+1] = i_cfg.joint_two_limit;
                    end
                end else if (l3) begin
                    n_goal[b]   = gcgs_pkg::add_cap(i_cfg.joint_one_limit, i_angle[b],
                                                    i_cfg.wide_margin);
                    n_goal[b+1] = gcgs_pkg::add_cap(i_cfg.joint_two_limit, i_angle[b+1],
                                                    {1'b0, i_cfg.stop_margin});
                    n_goal[b+2] = gcgs_pkg::add_cap(i_cfg.joint_three_limit, i_angle[b+2],
                                                    {1'b0, i_cfg.stop_margin});
                end else if (l2) begin
                    n_goal[b]   = gcgs_pkg::add_cap(i_cfg.joint_one_limit, i_angle[b],
                                                    {1'b0, i_cfg.stop_margin});
                    n_goal[b+1] = gcgs_pkg::add_cap(i_cfg.joint_two_limit, i_angle[b+1],
                                                    {1'b0, i_cfg.stop_margin});
                    n_goal[b+2] = i_cfg.joint_three_limit;
                end else begin
                    n_goal[b]   = gcgs_pkg::add_cap(i_cfg.joint_one_limit, i_angle[b],
                                                    {1'b0, i_cfg.stop_margin});
                    n_goal[b+1] = i_cfg.joint_two_limit;
                    n_goal[b+2] = i_cfg.joint_three_limit;
                end
            end
        end else if (i_close) begin
            for (int f = 0; f < 3; f++) begin
                if (jaws_closed) begin
                    n_goal[2*f]   = gcgs_pkg::add_cap(gcgs_pkg::CLOSE_ANGLE, i_angle[2*f],
                                                      {1'b0, i_cfg.stop_margin});
                    n_goal[2*f+1] = gcgs_pkg::sub_floor(gcgs_pkg::NEG_CLOSE_ANGLE,
                                                        i_angle[2*f+1], i_cfg.stop_margin);
                end else begin
                    n_goal[2*f]   = gcgs_pkg::CLOSE_ANGLE;
                    n_goal[2*f+1] = gcgs_pkg::NEG_CLOSE_ANGLE;
                end
            end
        end
    end

    assign o_goal = n_goal;
endmodule

// ===== hw/rtl/gripper_close_goal_sequencer_unit.sv =====
// Top level of the gripper close goal sequencer.
//
//   channel   dir   beat contents
//   i_cmd     in    close_req, contact_flags, angle_0 .. angle_8
//   o_goal    out   goal_0 .. goal_8
//   cfg       in    i_cfg_we, i_cfg_idx, i_cfg_wdata (write only)
//
// A command beat is registered, then the core logic computes its goals into
// the goal register, which is both the stored state and the result beat.
// One beat per cycle is sustained while the result is not stalled.
// A stalled result holds the goal register; the command register still takes
// one beat behind it. Reset clears all goals and loads the register defaults.
`include "gripper_close_goal_sequencer_unit_macros.svh"
module gripper_close_goal_sequencer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gcgs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcgs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    gcgs_cmd_if.sink                          i_cmd,
    gcgs_goal_if.source                       o_goal
);
    gcgs_pkg::t_cfg      cfg;
    logic                r_cmd_valid;
    logic                r_close;
    logic [8:0]          r_contact;
    gcgs_pkg::t_goal_vec r_angle;
    gcgs_pkg::t_goal_vec r_goal;
    gcgs_pkg::t_goal_vec n_goal;
    logic                r_out_valid;
    logic                advance;
    logic                cmd_take;

    gcgs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    gcgs_core u_core (
        .i_cfg     (cfg),
        .i_close   (r_close),
        .i_contact (r_contact),
        .i_angle   (r_angle),
        .i_goal    (r_goal),
        .o_goal    (n_goal)
    );

    assign advance     = r_cmd_valid && (!r_out_valid || o_goal.ready);
    assign i_cmd.ready = !r_cmd_valid || advance;
    assign cmd_take    = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_goal      <= '0;
        end else begin
            if (cmd_take) begin
                r_cmd_valid <= 1'b1;
            end else if (advance) begin
                r_cmd_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_goal      <= n_goal;
            end else if (o_goal.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take) begin
            r_close    <= i_cmd.close_req;
            r_contact  <= i_cmd.contact_flags[8:0];
            r_angle[0] <= i_cmd.angle_0;
            r_angle[1] <= i_cmd.angle_1;
            r_angle[2] <= i_cmd.angle_2;
            r_angle[3] <= i_cmd.angle_3;
            r_angle[4] <= i_cmd.angle_4;
            r_angle[5] <= i_cmd.angle_5;
            r_angle[6] <= i_cmd.angle_6;
            r_angle[7] <= i_cmd.angle_7;
            r_angle[8] <= i_cmd.angle_8;
        end
    end

    assign o_goal.valid  = r_out_valid;
    assign o_goal.goal_0 = r_goal[0];
    assign o_goal.goal_1 = r_goal[1];
    assign o_goal.goal_2 = r_goal[2];
    assign o_goal.goal_3 = r_goal[3];
    assign o_goal.goal_4 = r_goal[4];
    assign o_goal.goal_5 = r_goal[5];
    assign o_goal.goal_6 = r_goal[6];
    assign o_goal.goal_7 = r_goal[7];
    assign o_goal.goal_8 = r_goal[8];

    `GCGS_ASSERT_NEXT(a_stall_holds_goals, i_clk, i_rst_n, r_out_valid && !o_goal.ready, $stable(r_goal), "goals changed while result stalled")
    `GCGS_ASSERT_NEXT(a_open_keeps_goals, i_clk, i_rst_n, advance && !r_close, r_goal == $past(r_goal), "goals changed without close request")
    `GCGS_ASSERT_NEXT(a_pincher_keeps_upper, i_clk, i_rst_n, advance && cfg.pincher_mode, r_goal[8:6] == $past(r_goal[8:6]), "pincher mode touched goals 6 to 8")
    `GCGS_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid, i_cmd.ready, "command not ready with empty result")
endmodule
